// ----- rtl/core/wet_pkg.sv -----
package wet_pkg;

  localparam int unsigned Vertices  = 64;
  localparam int unsigned MaxDegree = 16;
  localparam int unsigned VtxW      = 6;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned DegW      = 5;
  localparam int unsigned AddrW     = VtxW + SlotW;
  localparam int unsigned WeightW   = 64;

  localparam logic [VtxW-1:0] LastVertex = VtxW'(Vertices - 1);
  localparam logic [DegW-1:0] DegFull    = DegW'(MaxDegree);

  localparam logic [2:0] ActAdd    = 3'd0;
  localparam logic [2:0] ActRemove = 3'd1;
  localparam logic [2:0] ActLookup = 3'd2;
  localparam logic [2:0] ActList   = 3'd3;
  localparam logic [2:0] ActMark   = 3'd4;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StUpdated = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StNoEdge  = 2'd3;

  // first member in the highest bits: status ends up in the lowest bits
  typedef struct packed {
    logic               neighbor_valid;
    logic [VtxW-1:0]    neighbor_vertex;
    logic [WeightW-1:0] found_weight;
    logic               edge_found;
    logic [1:0]         status;
  } result_t;

endpackage

// ----- rtl/core/weighted_edge_table_core.sv -----
// Channel | Dir | Signals            | Content
// s_axis  | in  | tvalid/tready/...  | one action item
// m_axis  | out | tvalid/tready/...  | result items, tlast on the final one
// apb     | in  | psel..prdata       | undirected_mode at address 0
// One item at a time. After reset a pass over all 64 vertices clears the degree and presence
// memories with s_axis_tready low. Each scanned slot passes S_SCAN and S_SCANW, and a miss
// ends in a final S_SCAN check; a remove moves each shifted slot through S_SHRD and S_SHWR.
// A stalled result holds in the output register; the scan pauses meanwhile.
module weighted_edge_table_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: action[2:0], from_vertex[8:3], to_vertex[14:9], edge_weight[78:15],
  //        present_flag[79]
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[1:0], edge_found[2], found_weight[66:3], neighbor_vertex[72:67],
  //        neighbor_valid[73], zero fill
  output logic [79:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOAD, S_SCAN, S_SCANW, S_DECIDE, S_SHRD, S_SHWR, S_LIST, S_LISTW,
    S_LISTP, S_OUT
  } state_e;

  state_e state_q;
  logic mode_q;
  logic [wet_pkg::VtxW-1:0] clr_q;

  // edge memories
  logic [wet_pkg::VtxW-1:0]    tgt_mem [wet_pkg::Vertices*wet_pkg::MaxDegree];
  logic [wet_pkg::WeightW-1:0] wgt_mem [wet_pkg::Vertices*wet_pkg::MaxDegree];
  logic [wet_pkg::VtxW-1:0]    tgt_rd;
  logic [wet_pkg::WeightW-1:0] wgt_rd;
  logic [wet_pkg::AddrW-1:0]   raddr, waddr;
  logic we_t, we_w;
  logic [wet_pkg::VtxW-1:0]    wtgt;
  logic [wet_pkg::WeightW-1:0] wwgt;

  // degree and presence memories
  logic [wet_pkg::DegW-1:0] deg_mem [wet_pkg::Vertices];
  logic                     pres_mem [wet_pkg::Vertices];
  logic [wet_pkg::DegW-1:0] degf_rd, degt_rd;
  logic                     pres_rd;
  logic                     deg_we, pres_we;
  logic [wet_pkg::VtxW-1:0] deg_wa, pres_wa;
  logic [wet_pkg::DegW-1:0] deg_wd;
  logic                     pres_wd;

  always_ff @(posedge clk_i) begin
    if (we_t) tgt_mem[waddr] <= wtgt;
    if (we_w) wgt_mem[waddr] <= wwgt;
    tgt_rd <= tgt_mem[raddr];
    wgt_rd <= wgt_mem[raddr];
  end

  // read both degrees of the offered item; look up presence of the read target
  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    if (pres_we) pres_mem[pres_wa] <= pres_wd;
    degf_rd <= deg_mem[s_axis_tdata[8:3]];
    degt_rd <= deg_mem[s_axis_tdata[14:9]];
    pres_rd <= pres_mem[tgt_rd];
  end

  logic [2:0] act_q;
  logic [wet_pkg::VtxW-1:0] f_q, t_q;
  logic [wet_pkg::WeightW-1:0] w_q;
  logic mir_q, dir_q;             // dir 0: f->t, 1: t->f
  logic [wet_pkg::SlotW:0] idx_q; // scan slot
  logic found0_q, found1_q, hit_q, any_q;
  logic [wet_pkg::SlotW-1:0] slot0_q, slot1_q;
  logic [wet_pkg::SlotW:0] cnt_q;
  logic [wet_pkg::WeightW-1:0] fw_q;
  logic [wet_pkg::DegW-1:0] degf_q, degt_q;
  wet_pkg::result_t res_q;
  logic last_q;

  logic [wet_pkg::VtxW-1:0] sv, st;
  logic [wet_pkg::DegW-1:0] sdeg;
  logic cur_found, sh_end;
  assign sv = dir_q ? t_q : f_q;
  assign st = dir_q ? f_q : t_q;
  assign sdeg = dir_q ? degt_q : degf_q;
  assign cur_found = dir_q ? found1_q : found0_q;
  assign sh_end = ({1'b0, idx_q} + 1'b1 >= {1'b0, sdeg});

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {6'd0, res_q};
  assign m_axis_tlast = last_q;
  assign pready = 1'b1;
  assign prdata = {31'd0, mode_q};

  // memory address and writes
  always_comb begin
    raddr = {sv, idx_q[wet_pkg::SlotW-1:0]};
    waddr = {sv, idx_q[wet_pkg::SlotW-1:0]};
    we_t = 1'b0; we_w = 1'b0;
    wtgt = tgt_rd; wwgt = wgt_rd;
    deg_we = 1'b0; deg_wa = sv; deg_wd = sdeg + 1'b1;
    pres_we = 1'b0; pres_wa = s_axis_tdata[8:3]; pres_wd = s_axis_tdata[79];
    unique case (state_q)
      S_CLR: begin
        deg_we = 1'b1; deg_wa = clr_q; deg_wd = '0;
        pres_we = 1'b1; pres_wa = clr_q; pres_wd = 1'b0;
      end
      S_IDLE: pres_we = s_axis_tvalid && (s_axis_tdata[2:0] == wet_pkg::ActMark);
      S_SHRD: begin
        raddr = {sv, idx_q[wet_pkg::SlotW-1:0] + 1'b1};
        deg_we = sh_end; deg_wd = sdeg - 1'b1;
      end
      S_SHWR: begin we_t = 1'b1; we_w = 1'b1; end
      S_DECIDE: begin
        if (act_q == wet_pkg::ActAdd && hit_q) begin
          we_w = 1'b1; wwgt = w_q; wtgt = st;
          if (cur_found)
            waddr = {sv, dir_q ? slot1_q : slot0_q};
          else begin
            waddr = {sv, sdeg[wet_pkg::SlotW-1:0]};
            we_t = 1'b1;
            deg_we = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  logic [wet_pkg::DegW-1:0] lim;
  assign lim = sdeg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      mode_q <= 1'b0;
      clr_q <= '0;
      last_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) mode_q <= pwdata[0];
      unique case (state_q)
        // clear one degree and presence entry a cycle
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == wet_pkg::LastVertex) state_q <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          act_q <= s_axis_tdata[2:0];
          f_q <= s_axis_tdata[8:3];
          t_q <= s_axis_tdata[14:9];
          w_q <= s_axis_tdata[78:15];
          mir_q <= mode_q && (s_axis_tdata[8:3] != s_axis_tdata[14:9]);
          dir_q <= 1'b0; idx_q <= '0; found0_q <= 1'b0; found1_q <= 1'b0;
          hit_q <= 1'b0; any_q <= 1'b0; cnt_q <= '0; fw_q <= '0;
          res_q <= '0; last_q <= 1'b1;
          priority case (s_axis_tdata[2:0])
            wet_pkg::ActMark: state_q <= S_OUT;
            wet_pkg::ActAdd, wet_pkg::ActRemove, wet_pkg::ActLookup, wet_pkg::ActList:
              state_q <= S_LOAD;
            default: state_q <= S_OUT;
          endcase
        end
        // take both degrees read at acceptance
        S_LOAD: begin
          degf_q <= degf_rd;
          degt_q <= degt_rd;
          state_q <= (act_q == wet_pkg::ActList) ? S_LIST : S_SCAN;
        end
        // read slot idx of the current list
        S_SCAN: begin
          if ({1'b0, idx_q} >= {1'b0, lim}) state_q <= S_DECIDE;
          else state_q <= S_SCANW;
        end
        S_SCANW: begin
          if (tgt_rd == st) begin
            if (dir_q) begin found1_q <= 1'b1; slot1_q <= idx_q[wet_pkg::SlotW-1:0]; end
            else begin
              found0_q <= 1'b1; slot0_q <= idx_q[wet_pkg::SlotW-1:0]; fw_q <= wgt_rd;
            end
            state_q <= S_DECIDE;
          end else begin
            idx_q <= idx_q + 1'b1; state_q <= S_SCAN;
          end
        end
        S_DECIDE: begin
          priority case (act_q)
            wet_pkg::ActLookup: begin
              res_q.status <= found0_q ? wet_pkg::StDone : wet_pkg::StNoEdge;
              res_q.edge_found <= found0_q;
              res_q.found_weight <= found0_q ? fw_q : '0;
              state_q <= S_OUT;
            end
            wet_pkg::ActRemove: begin
              if (cur_found) begin
                any_q <= 1'b1;
                idx_q <= {1'b0, dir_q ? slot1_q : slot0_q};
                state_q <= S_SHRD;
              end else if (!dir_q && mir_q) begin
                dir_q <= 1'b1; idx_q <= '0; state_q <= S_SCAN;
              end else begin
                res_q.status <= any_q ? wet_pkg::StDone : wet_pkg::StNoEdge;
                state_q <= S_OUT;
              end
            end
            default: begin // add: scan one list, or both when mirrored, then check, then write
              if (!hit_q) begin
                if (!dir_q && mir_q) begin
                  dir_q <= 1'b1; idx_q <= '0; state_q <= S_SCAN;
                end else begin
                  if ((!found0_q && degf_q == wet_pkg::DegFull) ||
                      (mir_q && !found1_q && degt_q == wet_pkg::DegFull)) begin
                    res_q.status <= wet_pkg::StFull; state_q <= S_OUT;
                  end else begin
                    hit_q <= 1'b1; dir_q <= 1'b0;
                  end
                end
              end else begin
                // write done this cycle for dir_q
                if (!cur_found) begin
                  if (dir_q) degt_q <= sdeg + 1'b1;
                  else degf_q <= sdeg + 1'b1;
                end
                if (!dir_q && mir_q) dir_q <= 1'b1;
                else begin
                  res_q.status <= found0_q ? wet_pkg::StUpdated : wet_pkg::StDone;
                  state_q <= S_OUT;
                end
              end
            end
          endcase
        end
        S_SHRD: begin
          if (sh_end) begin
            if (dir_q) degt_q <= sdeg - 1'b1;
            else degf_q <= sdeg - 1'b1;
            if (!dir_q && mir_q) begin
              dir_q <= 1'b1; idx_q <= '0; state_q <= S_SCAN;
            end else begin
              res_q.status <= wet_pkg::StDone; state_q <= S_OUT;
            end
          end else state_q <= S_SHWR;
        end
        S_SHWR: begin
          idx_q <= idx_q + 1'b1; state_q <= S_SHRD;
        end
        S_LIST: begin
          if ({1'b0, idx_q} >= {1'b0, lim}) begin
            if (cnt_q == '0) begin
              res_q <= '0; last_q <= 1'b1; state_q <= S_OUT;
            end else state_q <= S_OUT; // flush held neighbor as last
          end else state_q <= S_LISTW;
        end
        // target valid; wait for its presence bit
        S_LISTW: state_q <= S_LISTP;
        S_LISTP: begin
          idx_q <= idx_q + 1'b1;
          state_q <= S_LIST;
          if (pres_rd) begin
            if (cnt_q != '0) begin
              last_q <= 1'b0; state_q <= S_OUT; // emit held one first
              idx_q <= idx_q;
            end else begin
              res_q <= '0; res_q.neighbor_vertex <= tgt_rd; res_q.neighbor_valid <= 1'b1;
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_OUT: if (m_axis_tready) begin
          if (act_q == wet_pkg::ActList && !last_q) begin
            // load the pending neighbor (re-read at idx)
            cnt_q <= '0; last_q <= 1'b1; state_q <= S_LISTW;
          end else state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("accept during output");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_full_nochg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.status == wet_pkg::StFull |-> !res_q.edge_found)
    else $error("full with found");

endmodule
